FILE: hdl/accel_outlier_reject_magnitude_macros.svh
// Assertion macros for the accelerometer outlier reject block.
// Included by the checker module; no other dependencies.
`ifndef ACCEL_OUTLIER_REJECT_MAGNITUDE_MACROS_SVH
`define ACCEL_OUTLIER_REJECT_MAGNITUDE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define AORM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aorm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define AORM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aorm: next-cycle check failed");

`endif

FILE: hdl/aorm_pkg.sv
// Shared types and constants for the accelerometer outlier reject block.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package aorm_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UPPER_X = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOWER_X = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UPPER_Y = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOWER_Y = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UPPER_Z = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOWER_Z = 3'd5;

    // Limit reset values, Q4.12; truncated to the sample width where used
    localparam logic signed [31:0] RST_UPPER_X = 32'sd4781;
    localparam logic signed [31:0] RST_LOWER_X = -32'sd4773;
    localparam logic signed [31:0] RST_UPPER_Y = 32'sd7837;
    localparam logic signed [31:0] RST_LOWER_Y = -32'sd7385;
    localparam logic signed [31:0] RST_UPPER_Z = 32'sd5429;
    localparam logic signed [31:0] RST_LOWER_Z = -32'sd5140;

    // Result side-band: kept, flag_x, flag_y, flag_z
    localparam int M_TUSER_WIDTH = 4;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_ROOT,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic  capture;
        logic  sq_en;
        axis_t sq_axis;
        logic  root_step;
        logic  load_out;
    } aorm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic keep;
        logic out_free;
    } aorm_status_t;

endpackage

`default_nettype wire

FILE: hdl/accel_outlier_reject_magnitude.sv
// Accelerometer three-sigma outlier reject with vector magnitude.
// Usage:
//   Input stream s_*: one triple per request; s_tdata holds accel_x, accel_y,
//   accel_z (signed Q4.12), s_tlast marks the last triple of a recording and
//   clears the per-axis counters after that triple's result.
//   Result stream m_*: one request per input; m_tuser carries the keep and
//   per-axis out-of-limit flags, m_tdata the magnitude and the running counts.
//   Config port: cfg_wr_en writes cfg_wdata into limit register cfg_index
//   (0..5, upper/lower for x, y, z); other indexes are ignored. Write only idle.
// Sequence:
//   A triple is accepted in idle; the shared squarer then sums the squares of
//   x, y and z in turn. A kept triple then passes the restoring square root,
//   which produces one result bit per cycle; a rejected triple skips it and
//   carries a zero magnitude.
//   One item is in flight at a time; the next is accepted while the result
//   register still waits on m_tready, and a stalled result holds the sequencer
//   in its final state until the register frees up.
// Reset: aresetn low (synchronous) restores default limits, clears counters, drops m_tvalid.
// Depends on aorm_pkg, aorm_ctrl and aorm_dp.
`default_nettype none

module accel_outlier_reject_magnitude
    import aorm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    // input triple stream
    input  wire logic                                       s_tvalid,
    output logic                                            s_tready,
    // accel_x, accel_y, accel_z from bit 0 up, zero padded to bytes
    input  wire logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]        s_tdata,
    input  wire logic                                       s_tlast,
    // result stream
    output logic                                            m_tvalid,
    input  wire logic                                       m_tready,
    // magnitude, total_x, total_y, total_z from bit 0 up, zero padded to bytes
    output logic [((SAMPLE_WIDTH+3*COUNT_WIDTH+7)/8)*8-1:0] m_tdata,
    // kept, flag_x, flag_y, flag_z from bit 0 up
    output logic [M_TUSER_WIDTH-1:0]                        m_tuser,
    // limit register writes
    input  wire logic                                       cfg_wr_en,
    input  wire logic [CFG_INDEX_WIDTH-1:0]                 cfg_index,
    input  wire logic [SAMPLE_WIDTH-1:0]                    cfg_wdata
);

    localparam int W          = SAMPLE_WIDTH;
    localparam int C          = COUNT_WIDTH;
    localparam int M_TDATA_W  = ((W + 3*C + 7) / 8) * 8;

    aorm_cmd_t    cmd;
    aorm_status_t status;

    logic signed [W-1:0] accel_x, accel_y, accel_z;
    logic                kept, flag_x, flag_y, flag_z;
    logic [W-1:0]        magnitude;
    logic [C-1:0]        total_x, total_y, total_z;

    // Unpack the input request
    assign accel_x = s_tdata[W-1:0];
    assign accel_y = s_tdata[2*W-1:W];
    assign accel_z = s_tdata[3*W-1:2*W];

    aorm_ctrl #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    aorm_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .end_of_record (s_tlast),
        .cmd           (cmd),
        .status        (status),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .kept          (kept),
        .magnitude     (magnitude),
        .flag_x        (flag_x),
        .flag_y        (flag_y),
        .flag_z        (flag_z),
        .total_x       (total_x),
        .total_y       (total_y),
        .total_z       (total_z)
    );

    // Pack the result request
    assign m_tdata = M_TDATA_W'({total_z, total_y, total_x, magnitude});
    assign m_tuser = {flag_z, flag_y, flag_x, kept};

endmodule

`default_nettype wire

FILE: hdl/aorm_ctrl.sv
// Sequencer for the outlier reject block: squares, root iterations, output load.
// Depends on aorm_pkg for the state, command and status types.
`default_nettype none

module aorm_ctrl
    import aorm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire aorm_status_t status,
    output aorm_cmd_t         cmd
);

    localparam int STEP_W = $clog2(SAMPLE_WIDTH);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SAMPLE_WIDTH - 1);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // State and root step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SQ_X;
                end
            end
            ST_SQ_X: state_next = ST_SQ_Y;
            ST_SQ_Y: state_next = ST_SQ_Z;
            ST_SQ_Z: state_next = status.keep ? ST_ROOT : ST_DONE;
            ST_ROOT: begin
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // One root iteration per cycle, counted down to zero
    always_comb begin
        step_next = step_reg;
        if (state_reg == ST_SQ_Z) begin
            step_next = LAST_STEP;
        end else if (state_reg == ST_ROOT && step_reg != '0) begin
            step_next = step_reg - 1'b1;
        end
    end

    // Commands
    always_comb begin
        cmd         = '0;
        cmd.sq_axis = AXIS_X;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_SQ_X: begin
                cmd.sq_en   = 1'b1;
                cmd.sq_axis = AXIS_X;
            end
            ST_SQ_Y: begin
                cmd.sq_en   = 1'b1;
                cmd.sq_axis = AXIS_Y;
            end
            ST_SQ_Z: begin
                cmd.sq_en   = 1'b1;
                cmd.sq_axis = AXIS_Z;
            end
            ST_ROOT: cmd.root_step = 1'b1;
            ST_DONE: cmd.load_out  = status.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/aorm_dp.sv
// Datapath: limit registers, axis checks, counters, squarer, bit-serial root, result register.
// Depends on aorm_pkg for command/status types and register indexes.
`default_nettype none

module aorm_dp
    import aorm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  wire logic [SAMPLE_WIDTH-1:0]           cfg_wdata,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    accel_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    accel_y,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    accel_z,
    input  wire logic                              end_of_record,
    input  wire aorm_cmd_t                         cmd,
    output aorm_status_t                           status,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic                                   kept,
    output logic [SAMPLE_WIDTH-1:0]                magnitude,
    output logic                                   flag_x,
    output logic                                   flag_y,
    output logic                                   flag_z,
    output logic [COUNT_WIDTH-1:0]                 total_x,
    output logic [COUNT_WIDTH-1:0]                 total_y,
    output logic [COUNT_WIDTH-1:0]                 total_z
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int C  = COUNT_WIDTH;
    localparam logic [C-1:0] CNT_ONE = {{(C-1){1'b0}}, 1'b1};

    // Limits
    logic signed [W-1:0] lim_ux_reg, lim_lx_reg;
    logic signed [W-1:0] lim_uy_reg, lim_ly_reg;
    logic signed [W-1:0] lim_uz_reg, lim_lz_reg;

    // Captured item
    logic signed [W-1:0] x_reg, y_reg, z_reg;
    logic                keep_reg, fx_reg, fy_reg, fz_reg;
    logic [C-1:0]        tot_x_reg, tot_y_reg, tot_z_reg;

    // Record counters
    logic [C-1:0] cnt_x_reg, cnt_y_reg, cnt_z_reg;
    logic [C-1:0] cnt_x_next, cnt_y_next, cnt_z_next;

    // Sum of squares / radicand shifter, root and remainder
    logic [2*W-1:0] acc_reg, acc_next;
    logic [W-1:0]   root_reg, root_next;
    logic [W+1:0]   rem_reg, rem_next;

    // Result register
    logic           m_tvalid_reg;
    logic           out_kept_reg, out_fx_reg, out_fy_reg, out_fz_reg;
    logic [W-1:0]   out_mag_reg;
    logic [C-1:0]   out_tx_reg, out_ty_reg, out_tz_reg;

    logic           fx, fy, fz;
    logic signed [W-1:0] sel_val;
    logic [W-1:0]   sel_abs;
    logic [2*W-1:0] sq_prod;
    logic [W+3:0]   rem_shift, trial;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_ux_reg <= RST_UPPER_X[W-1:0];
            lim_lx_reg <= RST_LOWER_X[W-1:0];
            lim_uy_reg <= RST_UPPER_Y[W-1:0];
            lim_ly_reg <= RST_LOWER_Y[W-1:0];
            lim_uz_reg <= RST_UPPER_Z[W-1:0];
            lim_lz_reg <= RST_LOWER_Z[W-1:0];
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_UPPER_X: lim_ux_reg <= cfg_wdata;
                REG_LOWER_X: lim_lx_reg <= cfg_wdata;
                REG_UPPER_Y: lim_uy_reg <= cfg_wdata;
                REG_LOWER_Y: lim_ly_reg <= cfg_wdata;
                REG_UPPER_Z: lim_uz_reg <= cfg_wdata;
                REG_LOWER_Z: lim_lz_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Strict limit checks on the incoming triple
    assign fx = (accel_x > lim_ux_reg) || (accel_x < lim_lx_reg);
    assign fy = (accel_y > lim_uy_reg) || (accel_y < lim_ly_reg);
    assign fz = (accel_z > lim_uz_reg) || (accel_z < lim_lz_reg);

    // Saturating counter increments
    assign cnt_x_next = (fx && !(&cnt_x_reg)) ? cnt_x_reg + CNT_ONE : cnt_x_reg;
    assign cnt_y_next = (fy && !(&cnt_y_reg)) ? cnt_y_reg + CNT_ONE : cnt_y_reg;
    assign cnt_z_next = (fz && !(&cnt_z_reg)) ? cnt_z_reg + CNT_ONE : cnt_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_x_reg <= '0;
            cnt_y_reg <= '0;
            cnt_z_reg <= '0;
        end else if (cmd.capture) begin
            // totals include this item; record end clears afterwards
            cnt_x_reg <= end_of_record ? '0 : cnt_x_next;
            cnt_y_reg <= end_of_record ? '0 : cnt_y_next;
            cnt_z_reg <= end_of_record ? '0 : cnt_z_next;
        end
    end

    // Shared squarer on the selected axis magnitude
    always_comb begin
        unique case (cmd.sq_axis)
            AXIS_X:  sel_val = x_reg;
            AXIS_Y:  sel_val = y_reg;
            AXIS_Z:  sel_val = z_reg;
            default: sel_val = x_reg;
        endcase
        sel_abs = sel_val[W-1] ? W'(-sel_val) : W'(sel_val);
        sq_prod = (2*W)'(sel_abs) * (2*W)'(sel_abs);
    end

    // Restoring square root, one result bit per step
    assign rem_shift = {rem_reg, acc_reg[2*W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};

    always_comb begin
        acc_next  = acc_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        if (cmd.capture) begin
            acc_next  = '0;
            root_next = '0;
            rem_next  = '0;
        end else if (cmd.sq_en) begin
            acc_next = ((cmd.sq_axis == AXIS_X) ? '0 : acc_reg) + sq_prod;
        end else if (cmd.root_step) begin
            acc_next = {acc_reg[2*W-3:0], 2'b00};
            if (rem_shift >= trial) begin
                rem_next  = (W+2)'(rem_shift - trial);
                root_next = {root_reg[W-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift[W+1:0];
                root_next = {root_reg[W-2:0], 1'b0};
            end
        end
    end

    // Working registers (payload, no reset)
    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        if (cmd.capture) begin
            x_reg     <= accel_x;
            y_reg     <= accel_y;
            z_reg     <= accel_z;
            fx_reg    <= fx;
            fy_reg    <= fy;
            fz_reg    <= fz;
            keep_reg  <= !(fx || fy || fz);
            tot_x_reg <= cnt_x_next;
            tot_y_reg <= cnt_y_next;
            tot_z_reg <= cnt_z_next;
        end
    end

    // Result register: valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Result register: payload
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_kept_reg <= keep_reg;
            out_mag_reg  <= keep_reg ? root_reg : '0;
            out_fx_reg   <= fx_reg;
            out_fy_reg   <= fy_reg;
            out_fz_reg   <= fz_reg;
            out_tx_reg   <= tot_x_reg;
            out_ty_reg   <= tot_y_reg;
            out_tz_reg   <= tot_z_reg;
        end
    end

    assign status.keep     = keep_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid  = m_tvalid_reg;
    assign kept      = out_kept_reg;
    assign magnitude = out_mag_reg;
    assign flag_x    = out_fx_reg;
    assign flag_y    = out_fy_reg;
    assign flag_z    = out_fz_reg;
    assign total_x   = out_tx_reg;
    assign total_y   = out_ty_reg;
    assign total_z   = out_tz_reg;

endmodule

`default_nettype wire

FILE: hdl/aorm_checker.sv
// Port-level checks for accel_outlier_reject_magnitude, bound to the top level.
// Depends on aorm_pkg and the assertion macros header.
`default_nettype none

`include "accel_outlier_reject_magnitude_macros.svh"

module aorm_checker
    import aorm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input wire logic                                       aclk,
    input wire logic                                       aresetn,
    input wire logic                                       s_tvalid,
    input wire logic                                       s_tready,
    input wire logic                                       m_tvalid,
    input wire logic                                       m_tready,
    input wire logic [((SAMPLE_WIDTH+3*COUNT_WIDTH+7)/8)*8-1:0] m_tdata,
    input wire logic [M_TUSER_WIDTH-1:0]                   m_tuser
);

    localparam int W = SAMPLE_WIDTH;
    localparam int C = COUNT_WIDTH;

    logic [W-1:0] mag;
    logic [C-1:0] tx, ty, tz;
    logic         kept, fx, fy, fz;

    assign mag  = m_tdata[W-1:0];
    assign tx   = m_tdata[W+C-1:W];
    assign ty   = m_tdata[W+2*C-1:W+C];
    assign tz   = m_tdata[W+3*C-1:W+2*C];
    assign kept = m_tuser[0];
    assign fx   = m_tuser[1];
    assign fy   = m_tuser[2];
    assign fz   = m_tuser[3];

    // accepted request makes the block busy for the next cycle
    `AORM_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // stalled result holds
    `AORM_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // kept exactly when no axis flagged
    `AORM_ASSERT_IMPL(a_keep_flags, aclk, aresetn, m_tvalid, kept == !(fx || fy || fz))

    // rejected triple carries zero magnitude
    `AORM_ASSERT_IMPL(a_reject_zero, aclk, aresetn, m_tvalid && !kept, mag == '0)

    // a flagged axis has a nonzero running count
    `AORM_ASSERT_IMPL(a_flag_count, aclk, aresetn, m_tvalid, (!fx || tx != '0) && (!fy || ty != '0) && (!fz || tz != '0))

endmodule

bind accel_outlier_reject_magnitude aorm_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
) u_aorm_checker (.*);

`default_nettype wire
